[hdl/aaldb_pkg.sv]
// aaldb_pkg: shared constants, command and state codes, item structs
// for the anti-aliased line depth blend raster block
// no dependencies
package aaldb_pkg;

    // framebuffer geometry
    localparam int FB_WIDTH  = 64;
    localparam int FB_HEIGHT = 64;
    localparam int NPIX      = FB_WIDTH * FB_HEIGHT;
    localparam int IDX_W     = (NPIX > 1) ? $clog2(NPIX) : 1;

    // shared divider: dividend, divisor and quotient widths
    localparam int DIVD_W = 40;
    localparam int DIVS_W = 16;

    // depth accumulator width, Q.16
    localparam int ACC_W = 48;

    // reset values of the configuration registers
    localparam logic [6:0]  RST_ACT_W   = 7'd64;
    localparam logic [6:0]  RST_ACT_H   = 7'd64;
    localparam logic [15:0] RST_EPS     = 16'd66;
    localparam logic [8:0]  RST_DW_ALPHA = 9'd128;

    // command codes
    typedef enum logic [2:0] {
        CMD_LINE      = 3'd0,
        CMD_CLR_COLOR = 3'd1,
        CMD_CLR_DEPTH = 3'd2,
        CMD_SET       = 3'd3,
        CMD_SET_DT    = 3'd4,
        CMD_BLEND     = 3'd5,
        CMD_READ      = 3'd6,
        CMD_NONE      = 3'd7
    } t_cmd;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ACT_W    = 2'd0,
        CFG_ACT_H    = 2'd1,
        CFG_EPS      = 2'd2,
        CFG_DW_ALPHA = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LSWAP1,
        S_LSWAP2,
        S_LDIV,
        S_DIV_G,
        S_DIV_Z,
        S_EP,
        S_EPCOV,
        S_PLOT_RD,
        S_PLOT_WR,
        S_COL,
        S_PIX_RD,
        S_PIX_WR,
        S_DONE
    } t_state;

    // input item
    typedef struct packed {
        logic [2:0]          command;
        logic signed [15:0]  x_start;
        logic signed [15:0]  y_start;
        logic signed [15:0]  x_end;
        logic signed [15:0]  y_end;
        logic [15:0]         z_start;
        logic [15:0]         z_end;
        logic [31:0]         color;
        logic [8:0]          alpha;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [31:0] read_color;
        logic [15:0] read_depth;
        logic        in_range;
    } t_out_item;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hdl/aaldb_div.sv]
// aaldb_div: restoring divider, one quotient bit per cycle
// depends on aaldb_pkg
module aaldb_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [aaldb_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [aaldb_pkg::DIVS_W-1:0]   i_divisor,
    output aaldb_pkg::t_div_stat           o_stat,
    output logic [aaldb_pkg::DIVD_W-1:0]   o_quotient
);
    import aaldb_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [DIVS_W-1:0]   r_rem;
    logic [DIVS_W-1:0]   r_dvs;
    logic [DIVD_W-1:0]   r_quo;
    logic [DIVS_W:0]     rem_sh;
    logic [DIVS_W:0]     rem_sub;
    logic                ge;

    // trial subtract of the shifted remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIVD_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // one quotient bit per cycle, dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[hdl/aa_line_depth_blend_raster.sv]
// aa_line_depth_blend_raster: anti-aliased line rasterizer with depth test
// over on-chip color and depth stores; uses aaldb_pkg and aaldb_div
// Sequence: pixel commands read the addressed pixel and, if in range, write or return it;
//   clears sweep every pixel; a line does setup and two divisions (none for zero dx),
//   then a read and a write per in-range pixel, a read per skipped pixel, a step per interior column.
// Throughput: one item at a time, paced by the shared divider and the single store
//   port. Reset: a clearing pass over every pixel runs, input stalled.
module aa_line_depth_blend_raster (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  aaldb_pkg::t_in_item   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aaldb_pkg::t_out_item  o_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import aaldb_pkg::*;

    // per-byte blend, a of 0 keeps dst, 256 or more gives src
    function automatic logic [31:0] blend(input logic [31:0] dst,
                                          input logic [31:0] src,
                                          input logic [8:0]  a);
        logic [31:0] res;
        logic [8:0]  ia;
        logic [16:0] mix;
        res = dst;
        ia  = 9'd256 - a;
        if (a >= 9'd256) begin
            res = src;
        end else if (a != 9'd0) begin
            for (int i = 0; i < 4; i++) begin
                mix = 17'(src[i*8 +: 8] * a) + 17'(dst[i*8 +: 8] * ia);
                res[i*8 +: 8] = mix[15:8];
            end
        end
        return res;
    endfunction

    t_state    r_state, n_state;
    t_in_item  r_in;
    t_out_item r_res, r_out;
    logic      r_out_vld;

    // configuration
    logic [6:0]  r_cfg_w, r_cfg_h;
    logic [15:0] r_eps;
    logic [8:0]  r_dwa;

    // clearing pass
    logic [IDX_W-1:0] r_clr_cnt;
    logic             r_clr_col, r_clr_dep, r_clr_cmd;
    logic [31:0]      r_clr_val;

    // line setup
    logic               r_steep;
    logic signed [15:0] r_x0, r_y0, r_x1, r_y1;
    logic [15:0]        r_z0, r_z1;
    logic [15:0]        r_dx, r_dy_abs, r_dz_abs;
    logic               r_dy_neg, r_dz_neg;
    logic signed [17:0] r_g;
    logic signed [DIVD_W:0] r_step;
    logic               r_ep;
    logic signed [31:0] r_ye, r_inter;
    logic signed [15:0] r_xe, r_col, r_xp2;
    logic [8:0]         r_gap;
    logic signed [ACC_W-1:0] r_acc;

    // current pixel pair
    logic signed [15:0]      r_major, r_minor;
    logic signed [ACC_W-1:0] r_pacc;
    logic [8:0]              r_alo, r_ahi;
    logic                    r_half;

    // stores
    logic [31:0] mem_color [NPIX];
    logic [15:0] mem_depth [NPIX];
    logic [31:0] r_rd_color;
    logic [15:0] r_rd_depth;

    logic             c_we, d_we;
    logic [31:0]      wcolor;
    logic [15:0]      wdepth;
    logic [IDX_W-1:0] mem_addr;

    // divider
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVD_W-1:0] div_q;
    t_div_stat         div_stat;

    logic in_acc, out_load;

    aaldb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_dx),
        .o_stat     (div_stat),
        .o_quotient (div_q)
    );

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_load = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);

    // line setup: steep test and ordering
    logic signed [16:0] ddx1, ddy1, ddx2, ddy2, ddz2;
    logic [16:0]        adx1, ady1;
    logic               ord_swap;
    logic signed [15:0] xa, ya, xb, yb;
    logic [15:0]        za, zb;

    always_comb begin
        ddx1 = 17'(r_in.x_end) - 17'(r_in.x_start);
        ddy1 = 17'(r_in.y_end) - 17'(r_in.y_start);
        adx1 = ddx1[16] ? -ddx1 : ddx1;
        ady1 = ddy1[16] ? -ddy1 : ddy1;
        ord_swap = r_x0 > r_x1;
        xa = ord_swap ? r_x1 : r_x0;
        ya = ord_swap ? r_y1 : r_y0;
        za = ord_swap ? r_z1 : r_z0;
        xb = ord_swap ? r_x0 : r_x1;
        yb = ord_swap ? r_y0 : r_y1;
        zb = ord_swap ? r_z0 : r_z1;
        ddx2 = 17'(xb) - 17'(xa);
        ddy2 = 17'(yb) - 17'(ya);
        ddz2 = $signed({1'b0, zb}) - $signed({1'b0, za});
    end

    // endpoint: rounded x, y position in Q.16, x gap
    logic signed [15:0] ep_xp, ep_yp, ep_xe;
    logic signed [16:0] ep_xp17;
    logic [16:0]        ep_ax;
    logic [17:0]        ep_rsum;
    logic signed [24:0] ep_diff25;
    logic signed [9:0]  ep_diff;
    logic signed [27:0] ep_prod;
    logic signed [31:0] ep_ye;
    logic [7:0]         ep_graw;
    logic [8:0]         ep_gap;

    always_comb begin
        ep_xp     = r_ep ? r_x1 : r_x0;
        ep_yp     = r_ep ? r_y1 : r_y0;
        ep_xp17   = 17'(ep_xp);
        ep_ax     = ep_xp17[16] ? -ep_xp17 : ep_xp17;
        ep_rsum   = 18'(ep_ax) + 18'd128;
        ep_xe     = ep_xp[15] ? -$signed({6'b0, ep_rsum[17:8]})
                              :  $signed({6'b0, ep_rsum[17:8]});
        ep_diff25 = (25'(ep_xe) <<< 8) - 25'(ep_xp);
        ep_diff   = ep_diff25[9:0];
        ep_prod   = r_g * ep_diff;
        ep_ye     = (32'(ep_yp) <<< 8) + 32'(ep_prod >>> 8);
        ep_graw   = {~ep_xp[7], ep_xp[6:0]};
        ep_gap    = r_ep ? {1'b0, ep_graw} : 9'd256 - {1'b0, ep_graw};
    end

    // endpoint coverage
    logic [15:0] cv_fr;
    logic [16:0] cv_ifr;
    logic [25:0] cv_mlo;
    logic [24:0] cv_mhi;

    always_comb begin
        cv_fr  = r_ye[15:0];
        cv_ifr = 17'd65536 - {1'b0, cv_fr};
        cv_mlo = cv_ifr * r_gap;
        cv_mhi = cv_fr * r_gap;
    end

    // interior column coverage
    logic [15:0] cl_fr;
    logic [16:0] cl_ifr;
    logic        col_more;

    always_comb begin
        cl_fr    = r_inter[15:0];
        cl_ifr   = 17'd65536 - {1'b0, cl_fr};
        col_more = r_col < r_xp2;
    end

    // addressed pixel, bounds and store index
    logic signed [15:0] cur_x, cur_y, act_w, act_h;
    logic               pix_in, pix_state;
    logic [IDX_W-1:0]   pix_idx;
    logic [8:0]         pl_alpha;
    logic signed [ACC_W-17:0] pl_dhi;
    logic [15:0]        pl_depth;
    logic               pl_pass;

    always_comb begin
        pix_state = (r_state == S_PIX_RD) || (r_state == S_PIX_WR);
        if (pix_state) begin
            cur_x = 16'($signed(r_in.x_start[15:8]));
            cur_y = 16'($signed(r_in.y_start[15:8]));
        end else if (r_steep) begin
            cur_x = r_minor + 16'(r_half);
            cur_y = r_major;
        end else begin
            cur_x = r_major;
            cur_y = r_minor + 16'(r_half);
        end
        act_w  = (r_cfg_w < 7'(FB_WIDTH))  ? 16'(r_cfg_w) : 16'(FB_WIDTH);
        act_h  = (r_cfg_h < 7'(FB_HEIGHT)) ? 16'(r_cfg_h) : 16'(FB_HEIGHT);
        pix_in = !cur_x[15] && !cur_y[15] && (cur_x < act_w) && (cur_y < act_h);
        pix_idx = IDX_W'(32'($unsigned(cur_y)) * FB_WIDTH + 32'($unsigned(cur_x)));

        // line pixel depth and test
        pl_alpha = r_half ? r_ahi : r_alo;
        pl_dhi   = r_pacc[ACC_W-1:16];
        if (pl_dhi < 0)
            pl_depth = 16'd0;
        else if (pl_dhi > $signed((ACC_W-16)'(16'hFFFF)))
            pl_depth = 16'hFFFF;
        else
            pl_depth = pl_dhi[15:0];
        pl_pass = {1'b0, pl_depth} < ({1'b0, r_rd_depth} + {1'b0, r_eps});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == IDX_W'(NPIX - 1))
                    n_state = r_clr_cmd ? S_DONE : S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(i_in.command))
                        CMD_LINE:      n_state = S_LSWAP1;
                        CMD_CLR_COLOR,
                        CMD_CLR_DEPTH: n_state = S_CLEAR;
                        CMD_SET, CMD_SET_DT,
                        CMD_BLEND, CMD_READ: n_state = S_PIX_RD;
                        CMD_NONE:      n_state = S_DONE;
                    endcase
                end
            end
            S_LSWAP1:  n_state = S_LSWAP2;
            S_LSWAP2:  n_state = S_LDIV;
            S_LDIV:    n_state = (r_dx == 16'd0) ? S_EP : S_DIV_G;
            S_DIV_G:   if (div_stat.done) n_state = S_DIV_Z;
            S_DIV_Z:   if (div_stat.done) n_state = S_EP;
            S_EP:      n_state = S_EPCOV;
            S_EPCOV:   n_state = S_PLOT_RD;
            S_PLOT_RD, S_PLOT_WR: begin
                if (r_state == S_PLOT_RD && pix_in)
                    n_state = S_PLOT_WR;
                else if (!r_half)
                    n_state = S_PLOT_RD;
                else
                    n_state = r_ep ? S_COL : S_EP;
            end
            S_COL:     n_state = col_more ? S_PLOT_RD : S_DONE;
            S_PIX_RD:  n_state = pix_in ? S_PIX_WR : S_DONE;
            S_PIX_WR:  n_state = S_DONE;
            S_DONE:    if (out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs: store writes, divider start, input stall
    always_comb begin
        c_we         = 1'b0;
        d_we         = 1'b0;
        wcolor       = r_in.color;
        wdepth       = r_in.z_start;
        mem_addr     = pix_idx;
        div_start    = 1'b0;
        div_dividend = {8'd0, r_dy_abs, 16'd0};
        o_in_stall   = (r_state != S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                mem_addr = r_clr_cnt;
                c_we     = r_clr_col;
                d_we     = r_clr_dep;
                wcolor   = r_clr_val;
                wdepth   = 16'hFFFF;
            end
            S_LDIV: begin
                div_start = (r_dx != 16'd0);
            end
            S_DIV_G: begin
                div_start    = div_stat.done;
                div_dividend = {r_dz_abs, 24'd0};
            end
            S_PLOT_WR: begin
                c_we   = pl_pass;
                d_we   = pl_pass && (pl_alpha > r_dwa);
                wcolor = blend(r_rd_color, r_in.color, pl_alpha);
                wdepth = pl_depth;
            end
            S_PIX_WR: begin
                unique case (t_cmd'(r_in.command))
                    CMD_SET: c_we = 1'b1;
                    CMD_SET_DT: begin
                        c_we = r_in.z_start < r_rd_depth;
                        d_we = r_in.z_start < r_rd_depth;
                    end
                    CMD_BLEND: begin
                        c_we   = 1'b1;
                        wcolor = blend(r_rd_color, r_in.color, r_in.alpha);
                    end
                    CMD_LINE, CMD_CLR_COLOR, CMD_CLR_DEPTH,
                    CMD_READ, CMD_NONE: c_we = 1'b0;
                endcase
            end
            S_IDLE, S_LSWAP1, S_LSWAP2, S_DIV_Z, S_EP, S_EPCOV,
            S_PLOT_RD, S_COL, S_PIX_RD, S_DONE: c_we = 1'b0;
            default: c_we = 1'b0;
        endcase
    end

    // color store
    always_ff @(posedge i_clk) begin
        if (c_we)
            mem_color[mem_addr] <= wcolor;
        r_rd_color <= mem_color[mem_addr];
    end

    // depth store
    always_ff @(posedge i_clk) begin
        if (d_we)
            mem_depth[mem_addr] <= wdepth;
        r_rd_depth <= mem_depth[mem_addr];
    end

    // state, configuration, clearing pass and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cfg_w   <= RST_ACT_W;
            r_cfg_h   <= RST_ACT_H;
            r_eps     <= RST_EPS;
            r_dwa     <= RST_DW_ALPHA;
            r_clr_cnt <= '0;
            r_clr_col <= 1'b1;
            r_clr_dep <= 1'b1;
            r_clr_cmd <= 1'b0;
            r_clr_val <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACT_W:    r_cfg_w <= i_cfg_data[6:0];
                    CFG_ACT_H:    r_cfg_h <= i_cfg_data[6:0];
                    CFG_EPS:      r_eps   <= i_cfg_data;
                    CFG_DW_ALPHA: r_dwa   <= i_cfg_data[8:0];
                endcase
            end
            if (r_state == S_CLEAR)
                r_clr_cnt <= r_clr_cnt + 1'b1;
            if (in_acc) begin
                r_clr_cnt <= '0;
                r_clr_cmd <= 1'b1;
                r_clr_val <= i_in.color;
                r_clr_col <= (t_cmd'(i_in.command) == CMD_CLR_COLOR);
                r_clr_dep <= (t_cmd'(i_in.command) == CMD_CLR_DEPTH);
            end
            if (out_load)
                r_out_vld <= 1'b1;
            else if (!i_out_stall)
                r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load)
            r_out <= r_res;
        if (in_acc) begin
            r_in  <= i_in;
            r_res <= '0;
        end else if (r_state == S_PIX_RD) begin
            r_res.in_range <= pix_in;
        end else if (r_state == S_PIX_WR && t_cmd'(r_in.command) == CMD_READ) begin
            r_res.read_color <= r_rd_color;
            r_res.read_depth <= r_rd_depth;
        end
    end

    // line datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LSWAP1: begin
                r_steep <= ady1 > adx1;
                r_z0    <= r_in.z_start;
                r_z1    <= r_in.z_end;
                if (ady1 > adx1) begin
                    r_x0 <= r_in.y_start;
                    r_y0 <= r_in.x_start;
                    r_x1 <= r_in.y_end;
                    r_y1 <= r_in.x_end;
                end else begin
                    r_x0 <= r_in.x_start;
                    r_y0 <= r_in.y_start;
                    r_x1 <= r_in.x_end;
                    r_y1 <= r_in.y_end;
                end
            end
            S_LSWAP2: begin
                r_x0     <= xa;
                r_y0     <= ya;
                r_z0     <= za;
                r_x1     <= xb;
                r_y1     <= yb;
                r_z1     <= zb;
                r_dx     <= ddx2[15:0];
                r_dy_neg <= ddy2[16];
                r_dy_abs <= ddy2[16] ? 16'(-ddy2) : ddy2[15:0];
                r_dz_neg <= ddz2[16];
                r_dz_abs <= ddz2[16] ? 16'(-ddz2) : ddz2[15:0];
            end
            S_LDIV: begin
                r_ep   <= 1'b0;
                r_g    <= 18'sd65536;
                r_step <= '0;
            end
            S_DIV_G: begin
                if (div_stat.done)
                    r_g <= r_dy_neg ? -$signed({1'b0, div_q[16:0]})
                                    :  $signed({1'b0, div_q[16:0]});
            end
            S_DIV_Z: begin
                if (div_stat.done)
                    r_step <= r_dz_neg ? -$signed({1'b0, div_q})
                                       :  $signed({1'b0, div_q});
            end
            S_EP: begin
                r_ye  <= ep_ye;
                r_xe  <= ep_xe;
                r_gap <= ep_gap;
            end
            S_EPCOV: begin
                r_major <= r_xe;
                r_minor <= r_ye[31:16];
                r_pacc  <= ACC_W'({r_ep ? r_z1 : r_z0, 16'd0});
                r_alo   <= cv_mlo[24:16];
                r_ahi   <= cv_mhi[24:16];
                r_half  <= 1'b0;
                if (!r_ep) begin
                    r_inter <= r_ye + 32'(r_g);
                    r_acc   <= ACC_W'({r_z0, 16'd0}) + ACC_W'(r_step);
                    r_col   <= r_xe + 16'sd1;
                end else begin
                    r_xp2 <= r_xe;
                end
            end
            S_PLOT_RD, S_PLOT_WR: begin
                if (!(r_state == S_PLOT_RD && pix_in)) begin
                    r_half <= 1'b1;
                    if (r_half)
                        r_ep <= 1'b1;
                end
            end
            S_COL: begin
                if (col_more) begin
                    r_major <= r_col;
                    r_minor <= r_inter[31:16];
                    r_pacc  <= r_acc;
                    r_alo   <= cl_ifr[16:8];
                    r_ahi   <= {1'b0, cl_fr[15:8]};
                    r_half  <= 1'b0;
                    r_inter <= r_inter + 32'(r_g);
                    r_acc   <= r_acc + ACC_W'(r_step);
                    r_col   <= r_col + 16'sd1;
                end
            end
            S_CLEAR, S_IDLE, S_PIX_RD, S_PIX_WR, S_DONE: begin
                r_half <= r_half;
            end
            default: begin
                r_half <= r_half;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // the divider is started only when it is free
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // no store write while waiting for an item
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(c_we || d_we))
        else $error("store written while idle");

    // a new result appears only after the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside done state");
`endif

endmodule
